// ----- rtl/core/edcc_pkg.sv -----
package edcc_pkg;

    localparam int AMT_W     = 21;
    localparam int OP_W      = 2;
    localparam int CNT_W     = 24;
    localparam int OFF_W     = 29;
    localparam int DIVR_W    = 18;
    localparam int MREM_W    = 13;
    localparam int YC_W      = 9;
    localparam int DCNT_W    = 20;
    localparam int YEAR_W    = 13;
    localparam int MON_W     = 4;
    localparam int DOM_W     = 5;
    localparam int LEN_W     = 9;

    localparam logic [DIVR_W-1:0] CYCLE_DAYS   = DIVR_W'(146097);
    localparam logic [DIVR_W-1:0] CYCLE_MONTHS = DIVR_W'(4800);
    localparam logic [DIVR_W-1:0] CYCLE_YEARS  = DIVR_W'(400);
    localparam int                EPOCH_YEAR   = 1970;
    localparam logic [YC_W-1:0]   EPOCH_YC     = YC_W'(370);
    localparam logic [YC_W-1:0]   LAST_YC      = YC_W'(399);
    localparam logic [MON_W-1:0]  JAN          = MON_W'(1);
    localparam logic [MON_W-1:0]  FEB          = MON_W'(2);
    localparam logic [MON_W-1:0]  DEC          = MON_W'(12);

    // floor(2^RECIP_SH / divisor); for dividends below 2^32 the estimate is at most one low
    localparam int                  RECIP_SH     = 44;
    localparam int                  RECIP_W      = 32;
    localparam logic [RECIP_W-1:0]  RECIP_DAYS   =
        RECIP_W'((64'd1 << RECIP_SH) / 64'(CYCLE_DAYS));
    localparam logic [RECIP_W-1:0]  RECIP_MONTHS =
        RECIP_W'((64'd1 << RECIP_SH) / 64'(CYCLE_MONTHS));

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_DAYS   = 2'd1,
        OP_MONTHS = 2'd2,
        OP_YEARS  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIVM,
        ST_MULM,
        ST_WALK,
        ST_CHECK,
        ST_DIVD,
        ST_MULY,
        ST_YEAR,
        ST_MONTH,
        ST_DONE
    } state_t;

    // yc is the year modulo 400
    function automatic logic is_leap(input logic [YC_W-1:0] yc);
        logic century;
        century = (yc == YC_W'(100)) || (yc == YC_W'(200)) || (yc == YC_W'(300));
        return (yc[1:0] == 2'b00) && !century;
    endfunction

    function automatic logic [LEN_W-1:0] year_len(input logic [YC_W-1:0] yc);
        return is_leap(yc) ? LEN_W'(366) : LEN_W'(365);
    endfunction

    function automatic logic [LEN_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                   input logic [YC_W-1:0] yc);
        logic [LEN_W-1:0] len;
        case (m)
            FEB:                 len = is_leap(yc) ? LEN_W'(29) : LEN_W'(28);
            MON_W'(4), MON_W'(6),
            MON_W'(9), MON_W'(11): len = LEN_W'(30);
            default:             len = LEN_W'(31);
        endcase
        return len;
    endfunction

endpackage

// ----- rtl/core/edcc_div.sv -----
module edcc_div #(
    parameter int DW = 24
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic                        sel_days,
    input  logic [DW-1:0]               dividend,
    output logic                        done,
    output logic [DW-1:0]               quotient,
    output logic [edcc_pkg::DIVR_W-1:0] remainder
);

    import edcc_pkg::*;

    localparam int MW = DW + RECIP_W;
    localparam int RW = DIVR_W + 1;

    logic [4:0]         stage_reg, stage_next;
    logic               sel_reg, sel_next;
    logic [DW-1:0]      x_reg, x_next;
    logic [MW-1:0]      prod_reg, prod_next;
    logic [DW-1:0]      quo_reg, quo_next;
    logic [RW-1:0]      rem_reg, rem_next;
    logic [DIVR_W-1:0]  dvsr;
    logic [RECIP_W-1:0] recip;
    logic [DW+DIVR_W-1:0] back;

    // reciprocal multiply, back-multiply, one correction step
    assign dvsr  = sel_reg ? CYCLE_DAYS : CYCLE_MONTHS;
    assign recip = sel_reg ? RECIP_DAYS : RECIP_MONTHS;
    assign back  = quo_reg * dvsr;

    always_comb begin
        stage_next = {stage_reg[3:0], start};
        sel_next   = sel_reg;
        x_next     = x_reg;
        prod_next  = prod_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        if (start) begin
            sel_next = sel_days;
            x_next   = dividend;
        end
        if (stage_reg[0]) begin
            prod_next = x_reg * recip;
        end
        if (stage_reg[1]) begin
            quo_next = DW'(prod_reg[MW-1:RECIP_SH]);
        end
        if (stage_reg[2]) begin
            rem_next = RW'(x_reg - back[DW-1:0]);
        end
        if (stage_reg[3] && rem_reg >= {1'b0, dvsr}) begin
            quo_next = quo_reg + 1'b1;
            rem_next = rem_reg - {1'b0, dvsr};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= '0;
        end else begin
            stage_reg <= stage_next;
        end
        sel_reg  <= sel_next;
        x_reg    <= x_next;
        prod_reg <= prod_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
    end

    assign done      = stage_reg[4];
    assign quotient  = quo_reg;
    assign remainder = rem_reg[DIVR_W-1:0];

endmodule

// ----- rtl/core/epoch_day_calendar_counter.sv -----
// channel  dir  handshake          payload
// s_       in   s_valid / s_ready  s_op[1:0], s_amount[20:0] signed
// m_       out  m_valid / m_ready  m_day_count[19:0], m_year[12:0], m_month[3:0],
//                                  m_day_of_month[4:0], m_error
//
// Work per item: load/add days take Y + M steps; add months/years take R more, where
// Y (< 400) and M (< 12) are the year and month steps of the date decode and R (< 4800)
// the month steps of the walk. Each division by the 400-year cycle is a reciprocal
// multiply in the shared divider.
// Reset (aresetn low, synchronous): count 0, date 1970-01-01, no result pending.
// s_ready is high only in idle; the output register lets the next item in while a
// result waits on m_ready, and a second finished item waits in done.
module epoch_day_calendar_counter #(
    parameter int DAY_BITS = 20
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [edcc_pkg::OP_W-1:0]       s_op,
    input  logic signed [edcc_pkg::AMT_W-1:0] s_amount,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [edcc_pkg::DCNT_W-1:0]     m_day_count,
    output logic [edcc_pkg::YEAR_W-1:0]     m_year,
    output logic [edcc_pkg::MON_W-1:0]      m_month,
    output logic [edcc_pkg::DOM_W-1:0]      m_day_of_month,
    output logic                            m_error
);

    import edcc_pkg::*;

    localparam int DW = (DAY_BITS > CNT_W) ? DAY_BITS : CNT_W;
    localparam int CW = ((DAY_BITS > OFF_W) ? DAY_BITS : OFF_W) + 2;
    localparam int YW = (DAY_BITS > 20) ? DAY_BITS - 6 : 14;
    localparam int PW = DW + DIVR_W;

    state_t state_reg, state_next;

    logic [DAY_BITS-1:0] stored_reg, stored_next;
    logic [YW-1:0]       year_reg, year_next;
    logic [YC_W-1:0]     yc_reg, yc_next;
    logic [MON_W-1:0]    month_reg, month_next;
    logic [DOM_W-1:0]    dom_reg, dom_next;

    logic [YW-1:0]       wy_reg, wy_next;
    logic [YC_W-1:0]     wc_reg, wc_next;
    logic [MON_W-1:0]    wm_reg, wm_next;
    logic [MREM_W-1:0]   wcnt_reg, wcnt_next;
    logic [OFF_W-1:0]    off_reg, off_next;
    logic                neg_reg, neg_next;
    logic [CW-1:0]       cand_reg, cand_next;
    logic [DIVR_W-1:0]   rest_reg, rest_next;
    logic                err_reg, err_next;

    logic                  mv_reg, mv_next;
    logic [DCNT_W-1:0]     o_cnt_reg, o_cnt_next;
    logic [YEAR_W-1:0]     o_year_reg, o_year_next;
    logic [MON_W-1:0]      o_mon_reg, o_mon_next;
    logic [DOM_W-1:0]      o_dom_reg, o_dom_next;
    logic                  o_err_reg, o_err_next;

    logic              div_start;
    logic [DW-1:0]     div_dividend;
    logic              div_sel;
    logic              div_done;
    logic [DW-1:0]     div_quo;
    logic [DIVR_W-1:0] div_rem;

    logic [PW-1:0]      product;
    logic [AMT_W-1:0]   amt_abs;
    logic [CNT_W-1:0]   cnt_mag;
    logic [LEN_W-1:0]   wlen;
    logic [MON_W-1:0]   prev_m;
    logic [LEN_W-1:0]   ylen;
    logic [LEN_W-1:0]   mlen;
    logic               cand_bad;
    logic [DW-1:0]      stored_wide;

    edcc_div #(
        .DW (DW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .sel_days  (div_sel),
        .dividend  (div_dividend),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign product  = div_quo * ((state_reg == ST_MULM) ? CYCLE_DAYS : CYCLE_YEARS);
    assign amt_abs  = s_amount[AMT_W-1] ? AMT_W'(-s_amount) : AMT_W'(s_amount);
    assign cnt_mag  = (op_t'(s_op) == OP_YEARS) ?
                      (CNT_W'(amt_abs) << 3) + (CNT_W'(amt_abs) << 2) : CNT_W'(amt_abs);
    assign prev_m   = (wm_reg == JAN) ? DEC : wm_reg - 1'b1;
    assign wlen     = month_len(neg_reg ? prev_m : wm_reg, wc_reg);
    assign ylen     = year_len(wc_reg);
    assign mlen     = month_len(wm_reg, wc_reg);
    assign cand_bad = (cand_reg[CW-1:DAY_BITS] != '0);
    assign stored_wide = DW'(stored_reg);

    always_comb begin
        state_next   = state_reg;
        stored_next  = stored_reg;
        year_next    = year_reg;
        yc_next      = yc_reg;
        month_next   = month_reg;
        dom_next     = dom_reg;
        wy_next      = wy_reg;
        wc_next      = wc_reg;
        wm_next      = wm_reg;
        wcnt_next    = wcnt_reg;
        off_next     = off_reg;
        neg_next     = neg_reg;
        cand_next    = cand_reg;
        rest_next    = rest_reg;
        err_next     = err_reg;
        div_start    = 1'b0;
        div_dividend = DW'(cnt_mag);
        div_sel      = 1'b0;
        mv_next      = mv_reg && !m_ready;
        o_cnt_next   = o_cnt_reg;
        o_year_next  = o_year_reg;
        o_mon_next   = o_mon_reg;
        o_dom_next   = o_dom_reg;
        o_err_next   = o_err_reg;
        s_ready      = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    neg_next = s_amount[AMT_W-1];
                    wy_next  = year_reg;
                    wc_next  = yc_reg;
                    wm_next  = month_reg;
                    case (op_t'(s_op))
                        OP_LOAD: begin
                            cand_next  = CW'(s_amount);
                            state_next = ST_CHECK;
                        end
                        OP_DAYS: begin
                            cand_next  = CW'(stored_reg) + CW'(s_amount);
                            state_next = ST_CHECK;
                        end
                        default: begin
                            div_start  = 1'b1;
                            state_next = ST_DIVM;
                        end
                    endcase
                end
            end
            ST_DIVM: begin
                if (div_done) begin
                    wcnt_next  = div_rem[MREM_W-1:0];
                    state_next = ST_MULM;
                end
            end
            ST_MULM: begin
                off_next   = product[OFF_W-1:0];
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (wcnt_reg == '0) begin
                    cand_next  = neg_reg ? CW'(stored_reg) - CW'(off_reg)
                                         : CW'(stored_reg) + CW'(off_reg);
                    state_next = ST_CHECK;
                end else begin
                    wcnt_next = wcnt_reg - 1'b1;
                    off_next  = off_reg + OFF_W'(wlen);
                    if (neg_reg) begin
                        if (wm_reg == JAN) begin
                            wm_next = DEC;
                            wy_next = wy_reg - 1'b1;
                            wc_next = (wc_reg == '0) ? LAST_YC : wc_reg - 1'b1;
                        end else begin
                            wm_next = wm_reg - 1'b1;
                        end
                    end else begin
                        if (wm_reg == DEC) begin
                            wm_next = JAN;
                            wy_next = wy_reg + 1'b1;
                            wc_next = (wc_reg == LAST_YC) ? '0 : wc_reg + 1'b1;
                        end else begin
                            wm_next = wm_reg + 1'b1;
                        end
                    end
                end
            end
            ST_CHECK: begin
                if (cand_bad) begin
                    err_next   = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    err_next     = 1'b0;
                    stored_next  = cand_reg[DAY_BITS-1:0];
                    div_start    = 1'b1;
                    div_dividend = DW'(cand_reg[DAY_BITS-1:0]);
                    div_sel      = 1'b1;
                    state_next   = ST_DIVD;
                end
            end
            ST_DIVD: begin
                if (div_done) begin
                    state_next = ST_MULY;
                end
            end
            ST_MULY: begin
                wy_next    = YW'(EPOCH_YEAR) + product[YW-1:0];
                wc_next    = EPOCH_YC;
                wm_next    = JAN;
                rest_next  = div_rem;
                state_next = ST_YEAR;
            end
            ST_YEAR: begin
                if (rest_reg < DIVR_W'(ylen)) begin
                    state_next = ST_MONTH;
                end else begin
                    rest_next = rest_reg - DIVR_W'(ylen);
                    wy_next   = wy_reg + 1'b1;
                    wc_next   = (wc_reg == LAST_YC) ? '0 : wc_reg + 1'b1;
                end
            end
            ST_MONTH: begin
                if (rest_reg < DIVR_W'(mlen) || wm_reg >= DEC) begin
                    year_next  = wy_reg;
                    yc_next    = wc_reg;
                    month_next = wm_reg;
                    dom_next   = rest_reg[DOM_W-1:0] + 1'b1;
                    state_next = ST_DONE;
                end else begin
                    rest_next = rest_reg - DIVR_W'(mlen);
                    wm_next   = wm_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (!mv_reg || m_ready) begin
                    mv_next     = 1'b1;
                    o_cnt_next  = stored_wide[DCNT_W-1:0];
                    o_year_next = year_reg[YEAR_W-1:0];
                    o_mon_next  = month_reg;
                    o_dom_next  = dom_reg;
                    o_err_next  = err_reg;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            stored_reg <= '0;
            year_reg   <= YW'(EPOCH_YEAR);
            yc_reg     <= EPOCH_YC;
            month_reg  <= JAN;
            dom_reg    <= DOM_W'(1);
            mv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            stored_reg <= stored_next;
            year_reg   <= year_next;
            yc_reg     <= yc_next;
            month_reg  <= month_next;
            dom_reg    <= dom_next;
            mv_reg     <= mv_next;
        end
        wy_reg     <= wy_next;
        wc_reg     <= wc_next;
        wm_reg     <= wm_next;
        wcnt_reg   <= wcnt_next;
        off_reg    <= off_next;
        neg_reg    <= neg_next;
        cand_reg   <= cand_next;
        rest_reg   <= rest_next;
        err_reg    <= err_next;
        o_cnt_reg  <= o_cnt_next;
        o_year_reg <= o_year_next;
        o_mon_reg  <= o_mon_next;
        o_dom_reg  <= o_dom_next;
        o_err_reg  <= o_err_next;
    end

    assign m_valid        = mv_reg;
    assign m_day_count    = o_cnt_reg;
    assign m_year         = o_year_reg;
    assign m_month        = o_mon_reg;
    assign m_day_of_month = o_dom_reg;
    assign m_error        = o_err_reg;

    a_reject_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK && cand_bad) |=> $stable(stored_reg))
        else $error("rejected item changed the stored count");

    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (month_reg >= JAN && month_reg <= DEC && dom_reg != '0))
        else $error("cached date out of range");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIVM || state_reg == ST_DIVD))
        else $error("divider finished outside a wait state");

    a_walk_month: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (wm_reg >= JAN && wm_reg <= DEC))
        else $error("month walk left 1..12");

    a_done_loads_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && state_next == ST_IDLE) |=> m_valid)
        else $error("finished item not presented");

endmodule
